// ===== hdl/tkrs_pkg.sv =====
// package for the two-key record insertion sorter
// record type, cell control type, widths and defaults; no dependencies
package tkrs_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int TAG_W           = 8;
    localparam int LEVEL_W         = 4;
    localparam int SCORE_W         = 32;
    localparam int REC_W           = TAG_W + LEVEL_W + SCORE_W;
    localparam int TDATA_W         = ((REC_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [LEVEL_W-1:0]        level;
        logic [TAG_W-1:0]          tag;
    } t_rec;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    // true when stored record a stays ahead of the newer record b
    function automatic logic stays_ahead(input t_rec a, input t_rec b);
        logic res;
        if (a.level != b.level) begin
            res = a.level > b.level;
        end else begin
            res = a.score <= b.score;
        end
        return res;
    endfunction

endpackage

// ===== hdl/tkrs_cell.sv =====
// one cell of the sorting chain: holds a record, inserts or shifts it out
// depends on tkrs_pkg
module tkrs_cell (
    input  logic                i_clk,
    input  tkrs_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  tkrs_pkg::t_rec      i_new_rec,
    input  logic                i_prev_ahead,
    input  tkrs_pkg::t_rec      i_prev_rec,
    input  tkrs_pkg::t_rec      i_next_rec,
    output logic                o_ahead,
    output tkrs_pkg::t_rec      o_rec
);

    tkrs_pkg::t_rec r_rec;
    tkrs_pkg::t_rec n_rec;

    assign o_ahead = i_occ && tkrs_pkg::stays_ahead(r_rec, i_new_rec);
    assign o_rec   = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctrl.shift) begin
            n_rec = i_next_rec;
        end else if (i_ctrl.insert && !o_ahead) begin
            if (i_prev_ahead) begin
                n_rec = i_new_rec;
            end else begin
                n_rec = i_prev_rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// ===== hdl/two_key_record_insertion_sorter_unit.sv =====
// top level of the two-key record insertion sorter: chain of sorting cells
// depends on tkrs_pkg and tkrs_cell
//
// channel   dir  handshake                    contents
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: tag, level, score; tlast: final record
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: tag, level, score; tlast: end of list;
//                                             tuser: records dropped
//
// items are taken back to back while loading; each cell compares against the new item
// and keeps, takes it, or takes its left neighbor's record in that cycle
// after a final item the chain drains one record per cycle from cell 0 while
// m_axis_tready is high; no input is taken meanwhile
// synchronous active-low reset empties the chain; no clearing pass
// output stalls simply hold cell 0 and the chain
module two_key_record_insertion_sorter_unit #(
    parameter int MAX_RECORDS = tkrs_pkg::MAX_RECORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [tkrs_pkg::TDATA_W-1:0] s_axis_tdata,  // tag, level, score, zero pad
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [tkrs_pkg::TDATA_W-1:0] m_axis_tdata,  // tag, level, score, zero pad
    output logic                         m_axis_tlast,
    output logic                         m_axis_tuser   // records dropped
);

    localparam int CW = $clog2(MAX_RECORDS + 1);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_ovf, n_ovf;

    logic                 w_in_acc, w_out_acc, w_full;
    tkrs_pkg::t_rec       w_new;
    tkrs_pkg::t_cell_ctrl w_ctrl;
    tkrs_pkg::t_rec       w_rec   [MAX_RECORDS];
    logic                 w_ahead [MAX_RECORDS];

    assign w_new     = tkrs_pkg::t_rec'(s_axis_tdata[tkrs_pkg::REC_W-1:0]);
    assign w_full    = r_count == CW'(MAX_RECORDS);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = w_out_acc;

    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        tkrs_pkg::t_rec w_prev_rec, w_next_rec;
        logic           w_prev_ahead;
        if (i == 0) begin : g_first
            assign w_prev_rec   = w_new;
            assign w_prev_ahead = 1'b1;
        end else begin : g_mid
            assign w_prev_rec   = w_rec[i-1];
            assign w_prev_ahead = w_ahead[i-1];
        end
        if (i == MAX_RECORDS - 1) begin : g_last
            assign w_next_rec = w_rec[i];
        end else begin : g_inner
            assign w_next_rec = w_rec[i+1];
        end
        tkrs_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (r_count > CW'(i)),
            .i_new_rec    (w_new),
            .i_prev_ahead (w_prev_ahead),
            .i_prev_rec   (w_prev_rec),
            .i_next_rec   (w_next_rec),
            .o_ahead      (w_ahead[i]),
            .o_rec        (w_rec[i])
        );
    end

    assign s_axis_tready = r_state == ST_LOAD;
    assign m_axis_tvalid = r_state == ST_DRAIN;
    assign m_axis_tdata  = {{(tkrs_pkg::TDATA_W - tkrs_pkg::REC_W){1'b0}}, w_rec[0]};
    assign m_axis_tlast  = r_count == CW'(1);
    assign m_axis_tuser  = r_ovf;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_out_acc) begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_state = ST_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule
